### hdl/ale_pkg.sv
package ale_pkg;

  typedef logic [1:0] req_t;
  typedef logic [2:0] status_t;

  // Request kinds.
  localparam req_t REQ_INSERT  = 2'd0;
  localparam req_t REQ_REMOVE  = 2'd1;
  localparam req_t REQ_RESTART = 2'd2;
  localparam req_t REQ_NEXT    = 2'd3;

  // Result status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_END       = 3'd4;

  localparam int OUT_VALUE_BITS = 32;
  localparam int OUT_COUNT_BITS = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;    // latch the compare item of an accepted request
    logic    insert;      // append the incoming item if there is room
    logic    scan_start;  // reset the search pointer
    logic    scan;        // one search step
    logic    shift_start; // begin moving later entries down
    logic    shift;       // one shift step
    logic    dec;         // drop one from the fill count
    logic    cur_zero;    // cursor to the start
    logic    cur_inc;     // cursor forward, saturating
    logic    rd_cur;      // read the entry under the cursor
    logic    load_out;    // capture the result
    status_t res_status;
    logic    res_rd;      // result carries the read item
  } ale_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic scan_last;
    logic shift_done;
    logic cur_ok;
  } ale_stat_t;

endpackage

### hdl/ale_dp.sv
module ale_dp #(
  parameter int CAPACITY  = 64,
  parameter int ITEM_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ale_pkg::ale_cmd_t   cmd,
  output ale_pkg::ale_stat_t  stat,
  input  logic signed [31:0]  in_value_in,
  output logic signed [31:0]  out_value_out,
  output ale_pkg::status_t    out_status,
  output logic                out_list_empty,
  output logic [6:0]          out_item_count
);
  import ale_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ITEM_BITS-1:0] mem [CAPACITY];
  logic [ITEM_BITS-1:0] rd_data_r;
  logic [ITEM_BITS-1:0] item_r;
  logic [ITEM_BITS-1:0] item_in;
  logic [OUT_VALUE_BITS-1:0] rd_wide;

  logic [CW-1:0] count_r;
  logic [CW-1:0] cur_r;
  logic          cur_neg_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] chk_idx_r;
  logic          chk_vld_r;
  logic          wpend_r;
  logic [AW-1:0] waddr_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ITEM_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 shift_rd;

  generate
    if (ITEM_BITS >= OUT_VALUE_BITS) begin : g_wide
      assign item_in = ITEM_BITS'($unsigned(in_value_in));
      assign rd_wide = rd_data_r[OUT_VALUE_BITS-1:0];
    end else begin : g_narrow
      assign item_in = in_value_in[ITEM_BITS-1:0];
      assign rd_wide = OUT_VALUE_BITS'($signed(rd_data_r));
    end
  endgenerate

  assign stat.full       = (count_r == CW'(CAPACITY));
  assign stat.empty      = (count_r == '0);
  assign stat.hit        = chk_vld_r && (rd_data_r == item_r);
  assign stat.scan_last  = chk_vld_r && (chk_idx_r == CW'(count_r - 1'b1));
  assign stat.shift_done = (idx_r >= count_r) && !wpend_r;
  assign stat.cur_ok     = !cur_neg_r && (cur_r < count_r);

  assign shift_rd = cmd.shift && (idx_r < count_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = waddr_r;
    wr_data = rd_data_r;
    rd_en   = 1'b0;
    rd_addr = cur_r[AW-1:0];
    if (cmd.insert && !stat.full) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = item_in;
    end else if (cmd.shift && wpend_r) begin
      wr_en = 1'b1;
    end
    if (cmd.scan || shift_rd) begin
      rd_en   = 1'b1;
      rd_addr = idx_r[AW-1:0];
    end else if (cmd.rd_cur) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cur_r     <= '0;
      cur_neg_r <= 1'b1;
      idx_r     <= '0;
      chk_idx_r <= '0;
      chk_vld_r <= 1'b0;
      wpend_r   <= 1'b0;
      waddr_r   <= '0;
    end else begin
      if (cmd.insert && !stat.full) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (cmd.dec) begin
        count_r <= CW'(count_r - 1'b1);
      end

      if (cmd.cur_zero) begin
        cur_r     <= '0;
        cur_neg_r <= 1'b0;
      end else if (cmd.cur_inc) begin
        if (cur_neg_r) begin
          cur_r     <= '0;
          cur_neg_r <= 1'b0;
        end else if (cur_r != CW'(CAPACITY)) begin
          cur_r <= CW'(cur_r + 1'b1);
        end
      end

      if (cmd.scan_start) begin
        idx_r     <= '0;
        chk_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r     <= CW'(idx_r + 1'b1);
        chk_idx_r <= idx_r;
        chk_vld_r <= (idx_r < count_r);
      end else if (cmd.shift_start) begin
        idx_r     <= CW'(chk_idx_r + 1'b1);
        chk_vld_r <= 1'b0;
        wpend_r   <= 1'b0;
      end else if (cmd.shift) begin
        wpend_r <= shift_rd;
        if (shift_rd) begin
          idx_r   <= CW'(idx_r + 1'b1);
          waddr_r <= AW'(idx_r - 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      item_r <= item_in;
    end
    if (cmd.load_out) begin
      out_value_out  <= cmd.res_rd ? $signed(rd_wide) : '0;
      out_status     <= cmd.res_status;
      out_list_empty <= stat.empty;
      out_item_count <= OUT_COUNT_BITS'(count_r);
    end
  end

endmodule

### hdl/ale_ctrl.sv
module ale_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ale_pkg::req_t      in_req_type,
  output logic               out_valid,
  input  logic               out_stall,
  input  ale_pkg::ale_stat_t stat,
  output ale_pkg::ale_cmd_t  cmd
);
  import ale_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_r, state_nxt;
  status_t    res_status_r, res_status_nxt;
  logic       res_rd_r, res_rd_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    cmd.res_status = res_status_r;
    cmd.res_rd     = res_rd_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req   = 1'b1;
          res_rd_nxt     = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESULT;
          unique case (in_req_type)
            REQ_INSERT: begin
              cmd.insert = 1'b1;
              if (stat.full) begin
                res_status_nxt = ST_FULL;
              end
            end
            REQ_REMOVE: begin
              if (stat.empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            REQ_RESTART: begin
              cmd.cur_zero = 1'b1;
              state_nxt    = S_READ;
            end
            REQ_NEXT: begin
              cmd.cur_inc = 1'b1;
              state_nxt   = S_READ;
            end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else if (stat.scan_last) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESULT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.dec   = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_cur     = 1'b1;
        res_rd_nxt     = stat.cur_ok;
        res_status_nxt = stat.cur_ok ? ST_OK : ST_END;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_OK;
      res_rd_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_rd_r     <= res_rd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

### hdl/array_list_engine.sv
// Array-backed list of signed items kept in one single-port-write memory of
// CAPACITY entries, ITEM_BITS wide, starting at index zero. Each item on the
// input channel is a request: insert appends the value (status full when no
// room), remove deletes the first entry equal to the value and closes the gap
// (status empty or not found when it cannot), restart puts the read cursor on
// the first entry and returns it, and next steps the cursor and returns the
// entry there (status end of list past the last entry; the cursor stops at
// CAPACITY). Every request gives exactly one result item carrying the read
// value (zero when nothing is read), the status, and the fill count and empty
// flag after the request. An insert passes from acceptance to the result
// state and then into the output register, which it enters once the register
// is free; restart and next first pass a read state for the registered memory
// read. Remove is bounded by the memory's one read and one write per cycle:
// the search reads one entry per cycle up to the match, and the shift then
// moves one entry per cycle. One request is in flight at a time; the next item
// is accepted as soon as the previous result sits in the output register, even
// while the receiver stalls it.
// Stored entries have no reset; only entries below the fill count reach a result or the search.
module array_list_engine #(
  parameter int CAPACITY  = 64,
  parameter int ITEM_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ale_pkg::req_t      in_req_type,
  input  logic signed [31:0] in_value_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value_out,
  output ale_pkg::status_t   out_status,
  output logic               out_list_empty,
  output logic [6:0]         out_item_count
);
  import ale_pkg::*;

  // Commands flow from the sequencer to the datapath; status flows back.
  ale_cmd_t  cmd;
  ale_stat_t stat;

  ale_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // The datapath holds the entry memory, fill count, cursor, the search and
  // shift pointers, and the result register.
  ale_dp #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_value_in    (in_value_in),
    .out_value_out  (out_value_out),
    .out_status     (out_status),
    .out_list_empty (out_list_empty),
    .out_item_count (out_item_count)
  );

endmodule
